/* sv/json_string_unescape_defines.svh */
// Assertion macros shared by the string unescaper RTL.
`ifndef JSON_STRING_UNESCAPE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define JSU_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("check failed");
`define JSU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define JSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define JSU_ASSERT(lbl, cond)
`define JSU_ASSERT_IMPL(lbl, ante, cons)
`define JSU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/jsu_pkg.sv */
// Types, codes and helper functions of the JSON string unescaper.
`timescale 1ns / 1ps
package jsu_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [1:0]  kind_t;
    typedef logic [2:0]  phase_t;
    typedef logic [15:0] count_t;

    localparam kind_t KIND_CHAR    = 2'd0;
    localparam kind_t KIND_DONE    = 2'd1;
    localparam kind_t KIND_NOQUOTE = 2'd2;
    localparam kind_t KIND_BAD     = 2'd3;

    localparam phase_t PH_IDLE = 3'd0;
    localparam phase_t PH_STR  = 3'd1;
    localparam phase_t PH_ESC  = 3'd2;
    localparam phase_t PH_HEX1 = 3'd3;
    localparam phase_t PH_HEX4 = 3'd6;

    localparam byte_t CH_QUOTE = 8'h22;
    localparam byte_t CH_BSLASH = 8'h5C;
    localparam byte_t CH_SLASH = 8'h2F;
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_B = 8'h62;
    localparam byte_t CH_F = 8'h66;
    localparam byte_t CH_N = 8'h6E;
    localparam byte_t CH_R = 8'h72;
    localparam byte_t CH_T = 8'h74;
    localparam byte_t CH_U = 8'h75;

    localparam byte_t CODE_BS  = 8'd8;
    localparam byte_t CODE_TAB = 8'd9;
    localparam byte_t CODE_LF  = 8'd10;
    localparam byte_t CODE_FF  = 8'd12;
    localparam byte_t CODE_CR  = 8'd13;

    localparam count_t CAPACITY_RESET = 16'd256;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 3'd0;

    // Returns {is_hex, nibble} for one byte.
    function automatic logic [4:0] hex_digit(input byte_t c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

/* sv/json_string_unescape.sv */
// Top level of the JSON string unescaper: input register, decode step, result register.
`timescale 1ns / 1ps
`include "json_string_unescape_defines.svh"
// The block takes one raw byte per beat and sustains one byte per clock while
// out_ready stays high. A byte is held in an input register and then decoded
// in a single step against the parse state; a result it produces is captured
// in the result register that drives the output. Bytes that produce no result
// (whitespace, quotes that open a string, escape prefixes, hex digits and
// dropped characters) still pass through the decode step one by one. When a
// result waits on out_ready, the decode step stops and the input side takes
// at most one more byte into its register. The capacity register is written
// through the APB port at address 0 and should only be changed while idle.
module json_string_unescape (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  jsu_pkg::byte_t               in_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output jsu_pkg::kind_t               result_kind,
    output jsu_pkg::byte_t               out_char,
    output jsu_pkg::count_t              char_count,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [jsu_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import jsu_pkg::*;

    logic   capacity_we;
    count_t capacity_reg;

    logic   in_valid_reg;
    byte_t  in_byte_reg;

    phase_t phase_reg, phase_next;
    byte_t  hex_reg, hex_next;
    count_t count_reg, count_next;

    logic   out_valid_reg;
    kind_t  kind_reg, kind_next;
    byte_t  char_reg, char_next;
    count_t cnt_out_reg, cnt_out_next;

    logic   res_valid;
    logic   step_go;
    logic   store_req;
    byte_t  store_ch;
    count_t limit;
    logic [4:0] hexd;

    assign pready      = 1'b1;
    assign capacity_we = psel && penable && pwrite && (paddr == ADDR_CAPACITY);
    assign prdata      = (paddr == ADDR_CAPACITY) ? {16'd0, capacity_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (capacity_we)
        begin
            capacity_reg <= pwdata[15:0];
        end
    end

    assign step_go  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
        end
    end

    assign limit = (capacity_reg == 16'd0) ? 16'd0 : capacity_reg - 16'd1;
    assign hexd  = hex_digit(in_byte_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        hex_next     = hex_reg;
        count_next   = count_reg;
        res_valid    = 1'b0;
        kind_next    = KIND_CHAR;
        char_next    = 8'd0;
        cnt_out_next = count_reg;
        store_req    = 1'b0;
        store_ch     = in_byte_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (in_byte_reg inside {CH_SPACE, [CODE_TAB:CODE_CR]})
                begin
                    phase_next = PH_IDLE;
                end
                else if (in_byte_reg == CH_QUOTE)
                begin
                    count_next = 16'd0;
                    phase_next = PH_STR;
                end
                else
                begin
                    res_valid    = 1'b1;
                    kind_next    = KIND_NOQUOTE;
                    cnt_out_next = 16'd0;
                end
            end
            PH_STR:
            begin
                if (in_byte_reg == CH_QUOTE)
                begin
                    phase_next = PH_IDLE;
                    res_valid  = 1'b1;
                    kind_next  = KIND_DONE;
                end
                else if (in_byte_reg == CH_BSLASH)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    store_req = 1'b1;
                end
            end
            PH_ESC:
            begin
                phase_next = PH_STR;
                case (in_byte_reg)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: store_req = 1'b1;
                    CH_B:
                    begin
                        store_req = 1'b1;
                        store_ch  = CODE_BS;
                    end
                    CH_F:
                    begin
                        store_req = 1'b1;
                        store_ch  = CODE_FF;
                    end
                    CH_N:
                    begin
                        store_req = 1'b1;
                        store_ch  = CODE_LF;
                    end
                    CH_R:
                    begin
                        store_req = 1'b1;
                        store_ch  = CODE_CR;
                    end
                    CH_T:
                    begin
                        store_req = 1'b1;
                        store_ch  = CODE_TAB;
                    end
                    CH_U:
                    begin
                        hex_next   = 8'd0;
                        phase_next = PH_HEX1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        kind_next  = KIND_BAD;
                    end
                endcase
            end
            default:
            begin
                if (!hexd[4] || phase_reg > PH_HEX4)
                begin
                    phase_next = PH_IDLE;
                    res_valid  = 1'b1;
                    kind_next  = KIND_BAD;
                end
                else
                begin
                    hex_next = {hex_reg[3:0], hexd[3:0]};
                    if (phase_reg < PH_HEX4)
                    begin
                        phase_next = phase_reg + 3'd1;
                    end
                    else
                    begin
                        phase_next = PH_STR;
                        store_req  = 1'b1;
                        store_ch   = {hex_reg[3:0], hexd[3:0]};
                    end
                end
            end
        endcase
        if (store_req && (count_reg < limit))
        begin
            count_next   = count_reg + 16'd1;
            res_valid    = 1'b1;
            kind_next    = KIND_CHAR;
            char_next    = store_ch;
            cnt_out_next = count_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            hex_reg   <= 8'd0;
            count_reg <= 16'd0;
        end
        else if (step_go)
        begin
            phase_reg <= phase_next;
            hex_reg   <= hex_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_go)
        begin
            out_valid_reg <= res_valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go && res_valid)
        begin
            kind_reg    <= kind_next;
            char_reg    <= char_next;
            cnt_out_reg <= cnt_out_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign out_char    = char_reg;
    assign char_count  = cnt_out_reg;

    `JSU_ASSERT(phase_in_range, phase_reg <= PH_HEX4)
    `JSU_ASSERT_IMPL(char_has_count, out_valid && result_kind == KIND_CHAR, char_count != 16'd0)
    `JSU_ASSERT_IMPL(noquote_zero, out_valid && result_kind == KIND_NOQUOTE, char_count == 16'd0 && out_char == 8'd0)
    `JSU_ASSERT_NEXT(result_shows, step_go && res_valid, out_valid)

endmodule
